FILE: hdl/stereo_amplitude_imposer_assert.svh
// Assertion macros for the stereo amplitude imposer.
// Included by the files that hold concurrent assertions; no other dependencies.
`ifndef STEREO_AMPLITUDE_IMPOSER_ASSERT_SVH
`define STEREO_AMPLITUDE_IMPOSER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define SAI_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define SAI_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/sai_pkg.sv
// Shared types and constants of the stereo amplitude imposer.
// Used by the controller, the datapath and the top level; no dependencies.
package sai_pkg;

  // Fractional bits of the normalization gain.
  localparam int unsigned GAIN_FRAC = 16;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_STEP = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GAIN,
    ST_DIV,
    ST_MUL_HI,
    ST_MUL_LO,
    ST_MUL_MIX,
    ST_MIX,
    ST_MUL_PL,
    ST_MUL_PH,
    ST_ACC_PH,
    ST_SAT,
    ST_OUT
  } sai_state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_GAIN,
    OP_DIV,
    OP_MUL_HI,
    OP_MUL_LO,
    OP_MUL_MIX,
    OP_MIX,
    OP_MUL_PL,
    OP_MUL_PH,
    OP_ACC_PH,
    OP_SAT,
    OP_LOAD_OUT
  } sai_op_e;

  typedef struct packed {
    sai_op_e op;
    logic    chan;   // 0: left, 1: right
  } sai_cmd_t;

  typedef struct packed {
    logic gain_bypass;   // audio envelope lies above the threshold
  } sai_stat_t;

endpackage

FILE: hdl/sai_in_if.sv
// Input channel of the stereo amplitude imposer: one stereo frame per item.
// Standalone interface; no dependencies.
interface sai_in_if #(
  parameter int unsigned SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] mod_left;
  logic signed [SAMPLE_BITS-1:0] mod_right;
  logic signed [SAMPLE_BITS-1:0] audio_left;
  logic signed [SAMPLE_BITS-1:0] audio_right;

  modport source (
    output valid, mod_left, mod_right, audio_left, audio_right,
    input  ready
  );
  modport sink (
    input  valid, mod_left, mod_right, audio_left, audio_right,
    output ready
  );
endinterface

FILE: hdl/sai_out_if.sv
// Output channel of the stereo amplitude imposer: one stereo result per item.
// Standalone interface; no dependencies.
interface sai_out_if #(
  parameter int unsigned SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] imp_left;
  logic signed [SAMPLE_BITS-1:0] imp_right;

  modport source (
    output valid, imp_left, imp_right,
    input  ready
  );
  modport sink (
    input  valid, imp_left, imp_right,
    output ready
  );
endinterface

FILE: hdl/stereo_amplitude_imposer.sv
// Channel  | Direction | Handshake    | Payload
// in_i     | sink      | valid/ready  | mod_left, mod_right, audio_left, audio_right
// out_o    | source    | valid/ready  | imp_left, imp_right
// cfg      | write     | cfg_we_i     | cfg_idx_i selects depth, threshold, decay_step
//
// One item is worked on at a time. A channel whose audio envelope lies above the
// threshold skips the division; otherwise the shared restoring divider
// produces one gain bit per cycle for each channel in turn.
// Reset is asynchronous and active low; it restores the register defaults and
// clears the four envelopes. A result waits in the output register while the
// next item is accepted and computed; that item then holds until it is taken.

// Stereo amplitude imposer top level: instantiates controller and datapath.
// Depends on sai_pkg, sai_in_if, sai_out_if, sai_ctrl and sai_dp.
module stereo_amplitude_imposer
  import sai_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [SAMPLE_BITS-1:0] cfg_data_i,
  sai_in_if.sink                 in_i,
  sai_out_if.source              out_o
);

  // Commands flow from the controller to the datapath, status flows back.
  sai_cmd_t  cmd;
  sai_stat_t stat;
  logic      in_ready;
  logic      out_valid;

  // The controller walks each channel through gain, normalization, mix and
  // saturation, and owns both handshakes.
  sai_ctrl #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .out_valid_o(out_valid),
    .out_ready_i(out_o.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // The datapath holds the configuration, the envelopes, the divider, the one
  // shared multiplier and the output register.
  sai_dp #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .mod_left_i   (in_i.mod_left),
    .mod_right_i  (in_i.mod_right),
    .audio_left_i (in_i.audio_left),
    .audio_right_i(in_i.audio_right),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .imp_left_o   (out_o.imp_left),
    .imp_right_o  (out_o.imp_right)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;

endmodule

FILE: hdl/sai_ctrl.sv
// Controller of the stereo amplitude imposer: sequences the datapath per item.
// Depends on sai_pkg.
module sai_ctrl
  import sai_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  sai_stat_t stat_i,
  output sai_cmd_t  cmd_o
);

  localparam int unsigned DivSteps = SAMPLE_BITS + GAIN_FRAC;
  localparam int unsigned CntW     = $clog2(DivSteps);
  localparam logic [CntW-1:0] CntLast = CntW'(DivSteps - 1);

  sai_state_e      state_q, state_d;
  logic            chan_q, chan_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      chan_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      chan_q      <= chan_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    chan_d      = chan_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    in_ready_o  = 1'b0;
    cmd_o.op    = OP_NONE;
    cmd_o.chan  = chan_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_ACCEPT;
          chan_d   = 1'b0;
          state_d  = ST_GAIN;
        end
      end
      ST_GAIN: begin
        cmd_o.op = OP_GAIN;
        cnt_d    = '0;
        state_d  = stat_i.gain_bypass ? ST_MUL_HI : ST_DIV;
      end
      ST_DIV: begin
        cmd_o.op = OP_DIV;
        if (cnt_q == CntLast) begin
          state_d = ST_MUL_HI;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_MUL_HI: begin
        cmd_o.op = OP_MUL_HI;
        state_d  = ST_MUL_LO;
      end
      ST_MUL_LO: begin
        cmd_o.op = OP_MUL_LO;
        state_d  = ST_MUL_MIX;
      end
      ST_MUL_MIX: begin
        cmd_o.op = OP_MUL_MIX;
        state_d  = ST_MIX;
      end
      ST_MIX: begin
        cmd_o.op = OP_MIX;
        state_d  = ST_MUL_PL;
      end
      ST_MUL_PL: begin
        cmd_o.op = OP_MUL_PL;
        state_d  = ST_MUL_PH;
      end
      ST_MUL_PH: begin
        cmd_o.op = OP_MUL_PH;
        state_d  = ST_ACC_PH;
      end
      ST_ACC_PH: begin
        cmd_o.op = OP_ACC_PH;
        state_d  = ST_SAT;
      end
      ST_SAT: begin
        cmd_o.op = OP_SAT;
        if (chan_q) begin
          state_d = ST_OUT;
        end else begin
          chan_d  = 1'b1;
          state_d = ST_GAIN;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = OP_LOAD_OUT;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: hdl/sai_dp.sv
// Datapath of the stereo amplitude imposer: envelopes, divider, shared multiplier.
// Depends on sai_pkg; driven by sai_ctrl.
module sai_dp
  import sai_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [SAMPLE_BITS-1:0]        cfg_data_i,
  input  logic signed [SAMPLE_BITS-1:0] mod_left_i,
  input  logic signed [SAMPLE_BITS-1:0] mod_right_i,
  input  logic signed [SAMPLE_BITS-1:0] audio_left_i,
  input  logic signed [SAMPLE_BITS-1:0] audio_right_i,
  input  sai_cmd_t                      cmd_i,
  output sai_stat_t                     stat_o,
  output logic signed [SAMPLE_BITS-1:0] imp_left_o,
  output logic signed [SAMPLE_BITS-1:0] imp_right_o
);

  localparam int unsigned W  = SAMPLE_BITS;
  localparam int unsigned F  = SAMPLE_BITS - 1;
  localparam int unsigned QW = SAMPLE_BITS + GAIN_FRAC;
  localparam int unsigned PW = 2 * SAMPLE_BITS + 2;

  localparam longint unsigned OneL = 64'd1 << (SAMPLE_BITS - 1);
  localparam logic [W-1:0]   EnvFloor  = W'((OneL + 500) / 1000);
  localparam logic [W-1:0]   DepthRst  = W'(OneL);
  localparam logic [W-1:0]   ThrRst    = W'(OneL >> 1);
  localparam logic [W-1:0]   DecayRst  = W'((OneL + 5000) / 10000);
  localparam logic [W+1:0]   MixOne    = (W + 2)'(OneL);
  localparam logic [PW-1:0]  LimPos    = PW'(OneL - 1);
  localparam logic [PW-1:0]  LimNeg    = PW'(OneL);
  localparam logic [QW-1:0]  GainUnity = QW'(64'd1 << GAIN_FRAC);

  function automatic logic [W-1:0] mag(input logic [W-1:0] s);
    return s[W-1] ? (~s + 1'b1) : s;
  endfunction

  // Peak tracking: jump up, hold when equal, otherwise fall by the decay, clamped at zero.
  function automatic logic [W-1:0] track(input logic [W-1:0] env,
                                         input logic [W-1:0] a,
                                         input logic [W-1:0] dec);
    logic [W-1:0] r;
    if (a > env) begin
      r = a;
    end else if (a < env) begin
      r = (env > dec) ? (env - dec) : '0;
    end else begin
      r = env;
    end
    return r;
  endfunction

  // Configuration and envelope state.
  logic [W-1:0] depth_q, thr_q, decay_q;
  logic [W-1:0] env_ml_q, env_mr_q, env_al_q, env_ar_q;

  // Per-item working registers.
  logic [W-1:0]    aud_l_q, aud_r_q;
  logic [W-1:0]    amag_q;
  logic            neg_q;
  logic [QW-1:0]   num_q;
  logic [W-1:0]    rem_q, den_q;
  logic [2*W-1:0]  mul_q, nmag_q;
  logic [W-1:0]    mmag_q;
  logic [PW-1:0]   prodf_q;
  logic [W-1:0]    res_l_q, res_r_q, out_l_q, out_r_q;

  logic [W-1:0]    audio_c, aenv_c, menv_c;
  logic [W:0]      div_shift, div_diff;
  logic            div_ge;
  logic [W-1:0]    mul_a, mul_b;
  logic [2*W-1:0]  mul_p;
  logic [W-1:0]    mix_hi;
  logic [W+1:0]    mix_s;
  logic            mix_neg;
  logic [W-1:0]    mix_mag;
  logic [PW-1:0]   lim;
  logic [W-1:0]    sat, res_val;

  assign audio_c = cmd_i.chan ? aud_r_q : aud_l_q;
  assign aenv_c  = cmd_i.chan ? env_ar_q : env_al_q;
  assign menv_c  = cmd_i.chan ? env_mr_q : env_ml_q;

  assign stat_o.gain_bypass = aenv_c > thr_q;

  // One restoring division step per cycle.
  assign div_shift = {rem_q, num_q[QW-1]};
  assign div_diff  = div_shift - {1'b0, den_q};
  assign div_ge    = div_shift >= {1'b0, den_q};

  always_comb begin
    case (cmd_i.op)
      OP_MUL_HI: begin
        mul_a = amag_q;
        mul_b = num_q[QW-1:GAIN_FRAC];
      end
      OP_MUL_LO: begin
        mul_a = amag_q;
        mul_b = W'(num_q[GAIN_FRAC-1:0]);
      end
      OP_MUL_MIX: begin
        mul_a = menv_c;
        mul_b = depth_q;
      end
      OP_MUL_PL: begin
        mul_a = nmag_q[W-1:0];
        mul_b = mmag_q;
      end
      OP_MUL_PH: begin
        mul_a = nmag_q[2*W-1:W];
        mul_b = mmag_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Mix factor mod_env*depth + (1 - depth), kept as sign and magnitude.
  assign mix_hi  = mul_q[2*W-2:F];
  assign mix_s   = $signed({2'b00, mix_hi}) + $signed(MixOne) - $signed({2'b00, depth_q});
  assign mix_neg = mix_s[W+1];
  assign mix_mag = mix_neg ? W'(-mix_s) : W'(mix_s);

  assign lim     = neg_q ? LimNeg : LimPos;
  assign sat     = (prodf_q > lim) ? lim[W-1:0] : prodf_q[W-1:0];
  assign res_val = neg_q ? ('0 - sat) : sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= DepthRst;
      thr_q   <= ThrRst;
      decay_q <= DecayRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DEPTH:      depth_q <= cfg_data_i;
        CFG_THRESHOLD:  thr_q   <= cfg_data_i;
        CFG_DECAY_STEP: decay_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      env_ml_q <= '0;
      env_mr_q <= '0;
      env_al_q <= '0;
      env_ar_q <= '0;
    end else if (cmd_i.op == OP_ACCEPT) begin
      env_ml_q <= track(env_ml_q, mag(mod_left_i), decay_q);
      env_mr_q <= track(env_mr_q, mag(mod_right_i), decay_q);
      env_al_q <= track(env_al_q, mag(audio_left_i), decay_q);
      env_ar_q <= track(env_ar_q, mag(audio_right_i), decay_q);
    end
  end

  always_ff @(posedge clk_i) begin
    mul_q <= mul_p;
    case (cmd_i.op)
      OP_ACCEPT: begin
        aud_l_q <= audio_left_i;
        aud_r_q <= audio_right_i;
      end
      OP_GAIN: begin
        amag_q <= mag(audio_c);
        neg_q  <= audio_c[W-1];
        rem_q  <= '0;
        den_q  <= (aenv_c > EnvFloor) ? aenv_c : EnvFloor;
        if (stat_o.gain_bypass) begin
          num_q <= GainUnity;
        end else begin
          num_q <= {thr_q, {GAIN_FRAC{1'b0}}};
        end
      end
      OP_DIV: begin
        rem_q <= div_ge ? div_diff[W-1:0] : div_shift[W-1:0];
        num_q <= {num_q[QW-2:0], div_ge};
      end
      OP_MUL_LO: begin
        nmag_q <= mul_q;
      end
      OP_MUL_MIX: begin
        nmag_q <= nmag_q + (mul_q >> GAIN_FRAC);
      end
      OP_MIX: begin
        mmag_q <= mix_mag;
        neg_q  <= neg_q ^ mix_neg;
      end
      OP_MUL_PH: begin
        prodf_q <= PW'(mul_q >> F);
      end
      OP_ACC_PH: begin
        prodf_q <= prodf_q + PW'({mul_q, 1'b0});
      end
      OP_SAT: begin
        if (cmd_i.chan) begin
          res_r_q <= res_val;
        end else begin
          res_l_q <= res_val;
        end
      end
      OP_LOAD_OUT: begin
        out_l_q <= res_l_q;
        out_r_q <= res_r_q;
      end
      default: ;
    endcase
  end

  assign imp_left_o  = out_l_q;
  assign imp_right_o = out_r_q;

endmodule

FILE: hdl/sai_checker.sv
// Port-level checks for the stereo amplitude imposer, bound to the top level.
// Depends on stereo_amplitude_imposer_assert.svh and stereo_amplitude_imposer.
`include "stereo_amplitude_imposer_assert.svh"

module sai_checker #(
  parameter int unsigned SAMPLE_BITS = 24
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic signed [SAMPLE_BITS-1:0] imp_left_i,
  input logic signed [SAMPLE_BITS-1:0] imp_right_i
);

  // A stalled result stays offered.
  `SAI_ASSERT_NXT(out_hold_a, clk_i, rst_ni, out_valid_i && !out_ready_i,
                  out_valid_i, "result dropped while stalled")

  // A stalled result keeps its samples.
  `SAI_ASSERT_NXT(out_stable_a, clk_i, rst_ni, out_valid_i && !out_ready_i,
                  $stable(imp_left_i) && $stable(imp_right_i), "stalled result changed")

  // Only one item is in work: accepting an item closes the input.
  `SAI_ASSERT_NXT(one_item_a, clk_i, rst_ni, in_valid_i && in_ready_i,
                  !in_ready_i, "input open while an item is in work")

  // A new result appears exactly when the block returns to waiting for input.
  `SAI_ASSERT_IMP(result_frees_input_a, clk_i, rst_ni, $rose(out_valid_i),
                  in_ready_i, "result issued while an item is still in work")

endmodule

bind stereo_amplitude_imposer sai_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_sai_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_i.valid),
  .in_ready_i (in_i.ready),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .imp_left_i (out_o.imp_left),
  .imp_right_i(out_o.imp_right)
);

FILE: sim/sai_result_checker.sv
// Result checker for the stereo amplitude imposer: follows the configuration
// port and both channels, predicts every result and compares it on arrival.
// Depends on sai_pkg, sai_in_if and sai_out_if.
`timescale 1ns / 1ps

module sai_result_checker
  import sai_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [SAMPLE_BITS-1:0] cfg_data_i,
  sai_in_if                      in_mon,
  sai_out_if                     out_mon,
  output int unsigned            pending_o,
  output int unsigned            mismatches_o
);

  localparam int unsigned FRAC          = SAMPLE_BITS - 1;
  localparam logic [63:0] UNITY         = 64'd1 << FRAC;
  localparam logic [63:0] ENV_FLOOR     = (UNITY + 64'd500) / 64'd1000;
  localparam logic [63:0] DECAY_DEFAULT = (UNITY + 64'd5000) / 64'd10000;

  typedef logic [SAMPLE_BITS-1:0] word_t;
  typedef struct packed {
    word_t left;
    word_t right;
  } stereo_t;

  word_t   depth_q;
  word_t   thresh_q;
  word_t   decay_q;
  word_t   env_mod_l;
  word_t   env_mod_r;
  word_t   env_aud_l;
  word_t   env_aud_r;
  stereo_t imposed_due[$];

  // The most negative sample maps to exactly 1.0, which still fits unsigned.
  function automatic word_t magnitude(word_t s);
    return s[SAMPLE_BITS-1] ? word_t'(-s) : s;
  endfunction

  function automatic word_t follow_peak(word_t env, word_t level);
    if (level > env) return level;
    if (level < env) return (env > decay_q) ? env - decay_q : '0;
    return env;
  endfunction

  function automatic word_t impose_channel(word_t audio, word_t aenv, word_t menv);
    logic [63:0]        gain;
    logic [63:0]        den;
    logic [63:0]        nmag;
    logic [63:0]        scaled;
    logic [63:0]        mmag;
    logic [63:0]        prod;
    logic [63:0]        lim;
    logic signed [63:0] mix;
    logic               neg;
    neg = audio[SAMPLE_BITS-1];
    if (aenv > thresh_q) begin
      gain = 64'd1 << GAIN_FRAC;
    end else begin
      den  = (64'(aenv) > ENV_FLOOR) ? 64'(aenv) : ENV_FLOOR;
      gain = (64'(thresh_q) << GAIN_FRAC) / den;
    end
    nmag   = (64'(magnitude(audio)) * gain) >> GAIN_FRAC;
    scaled = (64'(menv) * 64'(depth_q)) >> FRAC;
    mix    = $signed(scaled) + $signed(UNITY) - $signed(64'(depth_q));
    if (mix < 0) begin
      neg  = ~neg;
      mmag = 64'(-mix);
    end else begin
      mmag = 64'(mix);
    end
    prod = (nmag * mmag) >> FRAC;
    lim  = neg ? UNITY : UNITY - 64'd1;
    if (prod > lim) prod = lim;
    return neg ? word_t'(-prod) : word_t'(prod);
  endfunction

  task automatic compare_field(string name, word_t want, word_t got);
    if (got !== want) begin
      mismatches_o++;
      $display("%0t: %s expected %0d, actual %0d", $time, name, $signed(want),
               $signed(got));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    stereo_t want;
    stereo_t got;
    if (!rst_ni) begin
      depth_q      = UNITY[SAMPLE_BITS-1:0];
      thresh_q     = word_t'(UNITY >> 1);
      decay_q      = DECAY_DEFAULT[SAMPLE_BITS-1:0];
      env_mod_l    = '0;
      env_mod_r    = '0;
      env_aud_l    = '0;
      env_aud_r    = '0;
      imposed_due.delete();
      pending_o    = 0;
      mismatches_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_DEPTH:      depth_q  = cfg_data_i;
          CFG_THRESHOLD:  thresh_q = cfg_data_i;
          CFG_DECAY_STEP: decay_q  = cfg_data_i;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        env_mod_l  = follow_peak(env_mod_l, magnitude(in_mon.mod_left));
        env_mod_r  = follow_peak(env_mod_r, magnitude(in_mon.mod_right));
        env_aud_l  = follow_peak(env_aud_l, magnitude(in_mon.audio_left));
        env_aud_r  = follow_peak(env_aud_r, magnitude(in_mon.audio_right));
        want.left  = impose_channel(in_mon.audio_left, env_aud_l, env_mod_l);
        want.right = impose_channel(in_mon.audio_right, env_aud_r, env_mod_r);
        imposed_due.push_back(want);
      end
      if (out_mon.valid && out_mon.ready) begin
        got.left  = out_mon.imp_left;
        got.right = out_mon.imp_right;
        if (imposed_due.size() == 0) begin
          mismatches_o++;
          $display("%0t: result expected none, actual %0d / %0d", $time,
                   $signed(got.left), $signed(got.right));
        end else begin
          want = imposed_due.pop_front();
          compare_field("imp_left", want.left, got.left);
          compare_field("imp_right", want.right, got.right);
        end
      end
      pending_o = imposed_due.size();
    end
  end

endmodule

FILE: sim/stereo_amplitude_imposer_tb.sv
// Testbench top of the stereo amplitude imposer: clock, reset, configuration
// writes and frame stimulus with random idling on both channels.
// Depends on sai_pkg, sai_in_if, sai_out_if, the block and sai_result_checker.
`timescale 1ns / 1ps

module stereo_amplitude_imposer_tb;
  import sai_pkg::*;

  localparam int unsigned SAMPLE_BITS  = 24;
  // A slow frame costs its computation plus the longest gaps on both sides, so
  // this limit leaves a wide margin.
  localparam int unsigned LIMIT_CYCLES = 3_000_000;
  localparam int unsigned TAIL_CYCLES  = 120;
  localparam int unsigned HOLD_CYCLES  = 600;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_FRAMES = 240;

  // Index 3 selects no register; writes to it must leave everything alone.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef logic [SAMPLE_BITS-1:0] word_t;

  localparam word_t S_MAX  = 24'h7FFFFF;
  localparam word_t S_MIN  = 24'h800000;
  localparam word_t Q_ONE  = 24'h800000;
  localparam word_t Q_HALF = 24'h400000;
  localparam word_t R_FULL = 24'hFFFFFF;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  word_t                cfg_data;
  int unsigned          frames_pending;
  int unsigned          mismatch_count;

  // When calm is set neither side idles, which gives back-to-back stretches.
  bit calm = 1'b0;
  // Set by the stimulus once; the receiver then holds off for a long stretch.
  bit long_hold_due = 1'b0;

  sai_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) in_if ();
  sai_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) out_if ();

  stereo_amplitude_imposer #(.SAMPLE_BITS(SAMPLE_BITS)) u_top (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .in_i      (in_if),
    .out_o     (out_if)
  );

  sai_result_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_mon      (in_if),
    .out_mon     (out_if),
    .pending_o   (frames_pending),
    .mismatches_o(mismatch_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Idle lengths: half the time none, mostly short, rarely a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 20);
    return $urandom_range(40, 150);
  endfunction

  // A sample is either fully random, an extreme, or bounded by the current
  // amplitude so that envelopes stay below the threshold long enough for the
  // normalization path to be exercised.
  function automatic word_t rand_sample(int unsigned amp_bits);
    word_t s;
    case ($urandom_range(0, 9))
      0, 1, 2: s = word_t'($urandom());
      3:       s = ($urandom_range(0, 1) != 0) ? S_MIN : S_MAX;
      default: begin
        s = word_t'($urandom_range(0, (1 << amp_bits) - 1));
        if ($urandom_range(0, 1) != 0) s = -s;
      end
    endcase
    return s;
  endfunction

  // Register values lean toward the corners: zero, exactly 1.0 and the full
  // 24-bit code (above 1.0), with random values in between.
  function automatic word_t pick_level();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return Q_ONE;
      2:       return R_FULL;
      default: return word_t'($urandom_range(0, Q_ONE));
    endcase
  endfunction

  function automatic word_t pick_decay();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return word_t'(839);
      2:       return R_FULL;
      3:       return word_t'($urandom_range(0, 1 << 12));
      4:       return word_t'($urandom_range(0, 1 << 18));
      default: return word_t'($urandom());
    endcase
  endfunction

  // Entered and left at a falling edge. A gap lowers valid first; otherwise
  // the next item follows right behind the previous one.
  task automatic push_frame(word_t m_l, word_t m_r, word_t a_l, word_t a_r);
    int unsigned gap;
    gap = calm ? 0 : pick_gap();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.mod_left    <= m_l;
    in_if.mod_right   <= m_r;
    in_if.audio_left  <= a_l;
    in_if.audio_right <= a_r;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Every frame yields a result, so the block is idle once nothing is due.
  task automatic settle();
    in_if.valid <= 1'b0;
    while (frames_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, word_t data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_levels(word_t depth, word_t thresh, word_t decay);
    cfg_write(CFG_DEPTH, depth);
    cfg_write(CFG_THRESHOLD, thresh);
    cfg_write(CFG_DECAY_STEP, decay);
  endtask

  // The receiver idles at random, stays ready for a short run, and once
  // holds off long enough that the block fills up and stops taking frames.
  initial begin : receiver
    int unsigned stall;
    out_if.ready = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (long_hold_due) begin
        long_hold_due = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        stall = calm ? 0 : pick_gap();
        if (stall != 0) begin
          out_if.ready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
      end
      out_if.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  end

  initial begin : watchdog
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("** stereo_amplitude_imposer: FAILED **");
    $finish;
  end

  initial begin : stimulus
    int unsigned amp_bits;
    cfg_we            = 1'b0;
    cfg_idx           = CFG_DEPTH;
    cfg_data          = '0;
    in_if.valid       = 1'b0;
    in_if.mod_left    = '0;
    in_if.mod_right   = '0;
    in_if.audio_left  = '0;
    in_if.audio_right = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Reset settings: silence, both extremes, a repeated frame that leaves
    // the envelopes where they are, the most negative sample rising past an
    // envelope one below it, then small samples that only decay.
    push_frame('0, '0, '0, '0);
    push_frame(S_MAX, S_MIN, S_MAX, S_MIN);
    push_frame(S_MAX, S_MIN, S_MAX, S_MIN);
    push_frame(S_MIN, S_MAX, S_MIN, S_MAX);
    push_frame(word_t'(1000), -word_t'(1000), -word_t'(1000), word_t'(1000));
    push_frame('0, '0, word_t'(1), -word_t'(1));

    // No imposition, threshold at 1.0, and a decay so large that envelopes
    // drop straight to zero: the gain then comes from the envelope floor.
    settle();
    set_levels('0, Q_ONE, R_FULL);
    push_frame(Q_HALF, -word_t'(1), word_t'(3000000), -word_t'(3000000));
    push_frame(word_t'(100), word_t'(200), word_t'(5), -word_t'(5));
    push_frame('0, '0, S_MAX, S_MIN);
    push_frame('0, '0, word_t'(1), -word_t'(1));
    push_frame('0, '0, word_t'(8000), -word_t'(8000));

    // Depth and threshold above 1.0 with no decay: large gains saturate and
    // a write to the spare index must not disturb anything.
    settle();
    set_levels(R_FULL, R_FULL, '0);
    cfg_write(CFG_SPARE, word_t'($urandom()));
    push_frame(S_MAX, S_MIN, word_t'(4000000), -word_t'(4000000));
    push_frame('0, '0, word_t'(4000000), -word_t'(4000000));
    push_frame('0, '0, -word_t'(1), word_t'(1));

    // Depth above 1.0 with the modulator envelopes collapsed to zero turns
    // the mix factor negative, which flips the output sign.
    settle();
    set_levels(R_FULL, Q_HALF, R_FULL);
    push_frame('0, '0, word_t'(2000), -word_t'(2000));
    push_frame(word_t'(100), -word_t'(100), S_MIN, S_MAX);
    push_frame(S_MIN, S_MAX, S_MAX, S_MIN);

    // Random phases, each under its own register settings. Every third phase runs
    // with no idling at all, and the long receiver hold falls in another.
    for (int unsigned p = 0; p < PHASES; p++) begin
      settle();
      set_levels(pick_level(), pick_level(), pick_decay());
      if (p % 3 == 0) cfg_write(CFG_SPARE, word_t'($urandom()));
      calm = (p % 3 == 1);
      if (p == 2) long_hold_due = 1'b1;
      amp_bits = 23;
      for (int unsigned n = 0; n < PHASE_FRAMES; n++) begin
        if (n % 20 == 0) amp_bits = $urandom_range(4, 23);
        push_frame(rand_sample(amp_bits), rand_sample(amp_bits),
                   rand_sample(amp_bits), rand_sample(amp_bits));
      end
    end
    calm = 1'b0;

    settle();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && frames_pending == 0) begin
      $display("** stereo_amplitude_imposer: PASSED **");
    end else begin
      $display("** stereo_amplitude_imposer: FAILED **");
    end
    $finish;
  end

endmodule
